// ===== design/rvx_pkg.sv =====
// Shared types and constants for the RV32I execute unit.
`default_nettype none
package rvx_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_FENCE  = 7'h0F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB   = 3'd0;
  localparam logic [2:0] F3_LH   = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_LHU  = 3'd5;

  localparam logic [4:0] REG_A7 = 5'd17;

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_ECALL   = 2'd1,
    ST_BREAK   = 2'd2,
    ST_ILLEGAL = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] npc;
    status_t     status;
    logic [31:0] call;
    logic        wr;
    logic [31:0] val;
    logic        load;
  } ex_res_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [2:0]  f3;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== design/rvx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/rvx_exec.sv =====
// Decode, ALU, branch resolution and address generation.
`default_nettype none
module rvx_exec (
  input  wire logic [31:0]       ins,
  input  wire logic [31:0]       pc,
  input  wire logic [2:0]        len,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output      rvx_pkg::ex_res_t  res,
  output      rvx_pkg::mem_req_t mreq
);
  import rvx_pkg::*;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [31:0] fall;
  logic [31:0] op2;
  logic [4:0]  sh;
  logic [31:0] alu;
  logic        alu_ok;
  logic        take;

  assign op    = ins[6:0];
  assign f3    = ins[14:12];
  assign f7    = ins[31:25];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_u = {ins[31:12], 12'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign fall  = pc + {29'b0, len};

  assign op2 = (op == OP_REG) ? b : imm_i;
  assign sh  = (op == OP_REG) ? b[4:0] : ins[24:20];

  // shared ALU for register and immediate forms
  always_comb begin
    alu    = '0;
    alu_ok = 1'b1;
    unique case (f3)
      F3_ADD: begin
        if (op == OP_REG && f7 == F7_ALT) alu = a - op2;
        else alu = a + op2;
        if (op == OP_REG && f7 != F7_BASE && f7 != F7_ALT) alu_ok = 1'b0;
      end
      F3_SLL: begin
        alu = a << sh;
        if (f7 != F7_BASE) alu_ok = 1'b0;
      end
      F3_SLT:  alu = {31'b0, $signed(a) < $signed(op2)};
      F3_SLTU: alu = {31'b0, a < op2};
      F3_XOR:  alu = a ^ op2;
      F3_SR: begin
        if (f7 == F7_ALT) alu = 32'($signed(a) >>> sh);
        else alu = a >> sh;
        if (f7 != F7_BASE && f7 != F7_ALT) alu_ok = 1'b0;
      end
      F3_OR:   alu = a | op2;
      F3_AND:  alu = a & op2;
      default: alu = '0;
    endcase
    // register form: only ADD/SUB and the right shifts take the alternate funct7
    if (op == OP_REG && f7 != F7_BASE && f3 != F3_ADD && f3 != F3_SR) alu_ok = 1'b0;
  end

  always_comb begin
    take = 1'b0;
    unique case (f3)
      F3_BEQ:  take = a == b;
      F3_BNE:  take = a != b;
      F3_BLT:  take = $signed(a) < $signed(b);
      F3_BGE:  take = $signed(a) >= $signed(b);
      F3_BLTU: take = a < b;
      F3_BGEU: take = a >= b;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    res        = '0;
    res.npc    = fall;
    res.status = ST_NORMAL;
    mreq       = '0;
    mreq.f3    = f3;
    mreq.wdata = b;
    mreq.addr  = a + imm_i;
    unique case (op)
      OP_LUI: begin
        res.wr  = 1'b1;
        res.val = imm_u;
      end
      OP_AUIPC: begin
        res.wr  = 1'b1;
        res.val = pc + imm_u;
      end
      OP_JAL: begin
        res.wr  = 1'b1;
        res.val = fall;
        res.npc = pc + imm_j;
      end
      OP_JALR: begin
        if (f3 != 3'd0) begin
          res.status = ST_ILLEGAL;
        end else begin
          res.wr  = 1'b1;
          res.val = fall;
          res.npc = (a + imm_i) & ~32'd1;
        end
      end
      OP_BRANCH: begin
        if (f3 == 3'd2 || f3 == 3'd3) res.status = ST_ILLEGAL;
        else if (take) res.npc = pc + imm_b;
      end
      OP_LOAD: begin
        if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU) begin
          res.wr   = 1'b1;
          res.load = 1'b1;
          mreq.rd  = 1'b1;
        end else begin
          res.status = ST_ILLEGAL;
        end
      end
      OP_STORE: begin
        mreq.addr = a + imm_s;
        if (f3 > 3'd2) res.status = ST_ILLEGAL;
        else mreq.wr = 1'b1;
      end
      OP_IMM, OP_REG: begin
        // immediate form has no funct7 except on the shifts
        if (alu_ok || (op == OP_IMM && f3 != F3_SLL && f3 != F3_SR)) begin
          res.wr  = 1'b1;
          res.val = alu;
        end else begin
          res.status = ST_ILLEGAL;
        end
      end
      OP_FENCE: begin
        if (f3 != 3'd0) res.status = ST_ILLEGAL;
      end
      OP_SYSTEM: begin
        if (ins == WORD_ECALL) begin
          res.status = ST_ECALL;
          res.call   = a;
        end else if (ins == WORD_EBREAK) begin
          res.status = ST_BREAK;
        end else begin
          res.status = ST_ILLEGAL;
        end
      end
      default: res.status = ST_ILLEGAL;
    endcase
    if (res.status == ST_BREAK || res.status == ST_ILLEGAL) begin
      res.npc = pc;
      res.wr  = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== design/rvx_dmem.sv =====
// Data memory: four byte banks, post-reset clearing pass and load alignment.
`default_nettype none
module rvx_dmem #(
  parameter int MEM_BYTES = 16384
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rvx_pkg::mem_req_t req,
  input  wire logic [2:0]        ld_f3,
  input  wire logic [1:0]        ld_lo,
  output      logic [31:0]       ld_val,
  output      logic              busy
);
  import rvx_pkg::*;

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = MEM_BYTES / 4;

  logic [RW:0] clr_r;
  logic [2:0]  nb;
  logic [7:0]  bank_q [4];
  logic [7:0]  lb [4];

  assign busy = ~clr_r[RW];
  assign nb   = (req.f3[1:0] == 2'd0) ? 3'd1 : (req.f3[1:0] == 2'd1) ? 3'd2 : 3'd4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (busy) begin
      clr_r <= clr_r + (RW+1)'(1);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]    off;
    logic [31:0]   baddr;
    logic [RW-1:0] row;
    logic [7:0]    wbyte;
    logic          en;

    assign off   = 2'(k) - req.addr[1:0];
    assign baddr = req.addr + {30'b0, off};
    assign row   = baddr[AW-1:2];
    assign en    = {1'b0, off} < nb;
    assign wbyte = req.wdata[8*off +: 8];

    rvx_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk   (clk),
      .we    (busy | (req.wr & en)),
      .waddr (busy ? clr_r[RW-1:0] : row),
      .wdata (busy ? 8'd0 : wbyte),
      .re    (req.rd),
      .raddr (row),
      .rdata (bank_q[k])
    );
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      lb[j] = bank_q[ld_lo + 2'(j)];
    end
    unique case (ld_f3)
      F3_LB:   ld_val = {{24{lb[0][7]}}, lb[0]};
      F3_LH:   ld_val = {{16{lb[1][7]}}, lb[1], lb[0]};
      F3_LW:   ld_val = {lb[3], lb[2], lb[1], lb[0]};
      F3_LBU:  ld_val = {24'b0, lb[0]};
      F3_LHU:  ld_val = {16'b0, lb[1], lb[0]};
      default: ld_val = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/rv32i_execute_unit.sv =====
// Top level of the RV32I execute unit: register file, pipeline and result register.
`default_nettype none
// Each instruction item passes through a register file read on accept, then an
// execute cycle that resolves the ALU, branch and memory address and issues the
// data memory access, then a writeback cycle that aligns load data, writes the
// register file and loads the result register. A new item is accepted as the
// previous one leaves writeback, so only one item is in execute or writeback at
// a time; the register file write-to-read turnaround is covered by a one-entry
// bypass. After reset the data memory is zeroed one 4-byte row per cycle, with
// input stalled. MEM_BYTES must be a power of two.
module rv32i_execute_unit #(
  parameter int MEM_BYTES = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [31:0] in_instruction,
  input  wire logic [31:0] in_pc,
  input  wire logic [2:0]  in_inst_length,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] out_next_pc,
  output      logic [1:0]  out_status,
  output      logic [31:0] out_call_number,
  output      logic        out_dest_written,
  output      logic [4:0]  out_dest_index,
  output      logic [31:0] out_dest_value
);
  import rvx_pkg::*;

  logic        in_acc, e_adv, m_adv, mem_busy;
  logic [4:0]  rs1, rs2;
  logic [31:0] vbits_r;

  logic        e_valid_r;
  logic [31:0] e_ins_r, e_pc_r;
  logic [2:0]  e_len_r;
  logic [4:0]  e_rs1_r, e_rs2_r;
  logic        e_av_r, e_bv_r;
  logic [31:0] rf_a, rf_b, op_a, op_b;

  logic        fwd_v_r;
  logic [4:0]  fwd_idx_r;
  logic [31:0] fwd_val_r;

  ex_res_t     ex;
  mem_req_t    mreq, mreq_g;

  logic        m_valid_r;
  ex_res_t     m_res_r;
  logic [4:0]  m_rd_r;
  logic [2:0]  m_f3_r;
  logic [1:0]  m_lo_r;
  logic [31:0] ld_val, wb_val;
  logic        wb_en;

  logic        out_valid_r;

  assign in_stall = mem_busy || e_valid_r || (m_valid_r && !m_adv);
  assign in_acc   = in_valid && !in_stall;
  assign m_adv    = m_valid_r && (!out_valid_r || !out_stall);
  assign e_adv    = e_valid_r && (!m_valid_r || m_adv);

  // ECALL has rs1 = x0, so port one fetches a7 instead for every SYSTEM instruction
  assign rs1 = (in_instruction[6:0] == OP_SYSTEM) ? REG_A7 : in_instruction[19:15];
  assign rs2 = in_instruction[24:20];

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(wb_en), .waddr(m_rd_r), .wdata(wb_val),
    .re(in_acc), .raddr(rs1), .rdata(rf_a)
  );
  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(wb_en), .waddr(m_rd_r), .wdata(wb_val),
    .re(in_acc), .raddr(rs2), .rdata(rf_b)
  );

  // last write bypass covers a write on the same edge as the read
  assign op_a = (fwd_v_r && fwd_idx_r == e_rs1_r) ? fwd_val_r : (e_av_r ? rf_a : 32'd0);
  assign op_b = (fwd_v_r && fwd_idx_r == e_rs2_r) ? fwd_val_r : (e_bv_r ? rf_b : 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (in_acc) begin
      e_valid_r <= 1'b1;
    end else if (e_adv) begin
      e_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_ins_r <= in_instruction;
      e_pc_r  <= in_pc;
      e_len_r <= in_inst_length;
      e_rs1_r <= rs1;
      e_rs2_r <= rs2;
      e_av_r  <= vbits_r[rs1];
      e_bv_r  <= vbits_r[rs2];
    end
  end

  rvx_exec u_exec (
    .ins(e_ins_r), .pc(e_pc_r), .len(e_len_r), .a(op_a), .b(op_b),
    .res(ex), .mreq(mreq)
  );

  always_comb begin
    mreq_g    = mreq;
    mreq_g.rd = mreq.rd && e_adv;
    mreq_g.wr = mreq.wr && e_adv;
  end

  rvx_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
    .clk(clk), .rst_n(rst_n), .req(mreq_g),
    .ld_f3(m_f3_r), .ld_lo(m_lo_r), .ld_val(ld_val), .busy(mem_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (e_adv) begin
      m_valid_r <= 1'b1;
    end else if (m_adv) begin
      m_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv) begin
      m_res_r <= ex;
      m_rd_r  <= e_ins_r[11:7];
      m_f3_r  <= mreq.f3;
      m_lo_r  <= mreq.addr[1:0];
    end
  end

  assign wb_val = m_res_r.load ? ld_val : m_res_r.val;
  assign wb_en  = m_adv && m_res_r.wr && (m_rd_r != 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r <= '0;
      fwd_v_r <= 1'b0;
    end else if (wb_en) begin
      vbits_r[m_rd_r] <= 1'b1;
      fwd_v_r         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      fwd_idx_r <= m_rd_r;
      fwd_val_r <= wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (m_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv) begin
      out_next_pc      <= m_res_r.npc;
      out_status       <= m_res_r.status;
      out_call_number  <= m_res_r.call;
      out_dest_written <= wb_en;
      out_dest_index   <= wb_en ? m_rd_r : 5'd0;
      out_dest_value   <= wb_en ? wb_val : 32'd0;
    end
  end

  assign out_valid = out_valid_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(e_valid_r && m_valid_r))
    else $error("execute and writeback stages both occupied");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> in_stall)
    else $error("item accepted during memory clear");

  a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (m_adv && (m_res_r.status == ST_BREAK || m_res_r.status == ST_ILLEGAL)) |-> !wb_en)
    else $error("halting item wrote the register file");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dest_written |-> out_dest_index != 5'd0)
    else $error("write reported to x0");

endmodule
`default_nettype wire
